// ===== rtl/core/rbv_pkg.sv =====
package rbv_pkg;

  // Field and arithmetic widths.
  localparam int IN_W       = 16;
  localparam int OUT_FRAC   = 14;
  localparam int OUT_W      = OUT_FRAC + 2;
  localparam int IN_TDATA_W = ((6 * IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((4 * OUT_W + 7) / 8) * 8;
  localparam int VW         = 32;
  localparam int UNIT_SHIFT = 30;
  localparam int SHIFT_W    = $clog2(UNIT_SHIFT + 1);
  localparam int MAG_W      = VW + UNIT_SHIFT;
  localparam int SQRT_STEPS = 32;
  localparam int QUO_BITS   = 33;
  localparam int QW         = QUO_BITS + 2;

  // Pipeline depths of the two reusable units.
  localparam int PN_LAT = 4;
  localparam int SD_LAT = SQRT_STEPS + QUO_BITS + 2;

  // Nearly-opposite limit on the Q.30 cosine, and the axis limit in Q.60.
  localparam logic signed [33:0] OPP_THRESHOLD  = -34'sd1072668082;
  localparam logic signed [63:0] AXIS_THRESHOLD = 64'sd11529215046068470;

  typedef logic [2:0][VW-1:0]    vec_t;
  typedef logic [2:0][MAG_W-1:0] mag3_t;
  typedef logic [2:0][QW-1:0]    quo3_t;

  // Q.30 value to Q1.OUT_FRAC, rounded half away from zero, then saturated.
  function automatic logic [OUT_W-1:0] to_out(input logic [QW-1:0] q);
    logic [QW-1:0] mag;
    logic [QW-1:0] r;
    logic [QW-1:0] lim;
    mag = q[QW-1] ? QW'(-q) : q;
    r   = (mag + (QW'(1) << (UNIT_SHIFT - OUT_FRAC - 1))) >> (UNIT_SHIFT - OUT_FRAC);
    lim = QW'(1) << OUT_FRAC;
    if (r > lim) begin
      r = lim;
    end
    return q[QW-1] ? OUT_W'(-r) : OUT_W'(r);
  endfunction

endpackage

// ===== rtl/core/rbv_prenorm.sv =====
// Scales a vector so that its largest component reaches 2^30, then forms the
// sum of squares and the Q.60 numerators for the unit-length division.
module rbv_prenorm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rbv_pkg::vec_t       in_vec,
  output logic                out_valid,
  output logic                out_zero,
  output logic [63:0]         out_sum,
  output rbv_pkg::mag3_t      out_mag,
  output logic [2:0]          out_neg
);

  logic [rbv_pkg::PN_LAT-1:0]  v_r;
  logic [rbv_pkg::VW-1:0]      mag_in [3];
  logic [rbv_pkg::VW-1:0]      m;
  rbv_pkg::vec_t               s1_vec_r;
  logic [rbv_pkg::SHIFT_W-1:0] s1_k_r, s1_k_nxt;
  logic                        s1_z_r, s1_z_nxt;
  rbv_pkg::vec_t               s2_w_r, s2_w_nxt;
  logic                        s2_z_r;
  logic [rbv_pkg::VW-1:0]      s3_mag_r [3];
  logic [rbv_pkg::VW-1:0]      s3_mag_nxt [3];
  logic [63:0]                 s3_sq_r [3];
  logic [63:0]                 s3_sq_nxt [3];
  logic [2:0]                  s3_neg_r;
  logic                        s3_z_r;
  logic [63:0]                 s4_sum_r;
  rbv_pkg::mag3_t              s4_mag_r;
  logic [2:0]                  s4_neg_r;
  logic                        s4_z_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = in_vec[i][rbv_pkg::VW-1] ? rbv_pkg::VW'(-in_vec[i]) : in_vec[i];
    end
    m = mag_in[0];
    if (mag_in[1] > m) begin
      m = mag_in[1];
    end
    if (mag_in[2] > m) begin
      m = mag_in[2];
    end
    // Highest set bit below 2^30 decides the left shift.
    s1_k_nxt = '0;
    for (int i = 0; i < rbv_pkg::UNIT_SHIFT; i++) begin
      if (m[i]) begin
        s1_k_nxt = rbv_pkg::SHIFT_W'(rbv_pkg::UNIT_SHIFT - i);
      end
    end
    s1_z_nxt = (m == '0);
    for (int i = 0; i < 3; i++) begin
      s2_w_nxt[i]   = s1_vec_r[i] << s1_k_r;
      s3_mag_nxt[i] = s2_w_r[i][rbv_pkg::VW-1] ? rbv_pkg::VW'(-s2_w_r[i]) : s2_w_r[i];
      s3_sq_nxt[i]  = s3_mag_nxt[i] * s3_mag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[rbv_pkg::PN_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vec_r <= in_vec;
      s1_k_r   <= s1_k_nxt;
      s1_z_r   <= s1_z_nxt;
      s2_w_r   <= s2_w_nxt;
      s2_z_r   <= s1_z_r;
      s3_mag_r <= s3_mag_nxt;
      s3_sq_r  <= s3_sq_nxt;
      for (int i = 0; i < 3; i++) begin
        s3_neg_r[i] <= s2_w_r[i][rbv_pkg::VW-1];
        s4_mag_r[i] <= {s3_mag_r[i], rbv_pkg::UNIT_SHIFT'(0)};
      end
      s3_z_r   <= s2_z_r;
      s4_sum_r <= s3_sq_r[0] + s3_sq_r[1] + s3_sq_r[2];
      s4_neg_r <= s3_neg_r;
      s4_z_r   <= s3_z_r;
    end
  end

  assign out_valid = v_r[rbv_pkg::PN_LAT-1];
  assign out_zero  = s4_z_r;
  assign out_sum   = s4_sum_r;
  assign out_mag   = s4_mag_r;
  assign out_neg   = s4_neg_r;

endmodule

// ===== rtl/core/rbv_sqrtdiv.sv =====
// Pipelined integer square root, one result bit per stage, followed by three
// restoring dividers that divide signed numerators by that root, rounded to
// nearest with ties away from zero.
module rbv_sqrtdiv (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [63:0]    in_sum,
  input  rbv_pkg::mag3_t in_mag,
  input  logic [2:0]     in_neg,
  output logic           out_valid,
  output logic [31:0]    out_root,
  output rbv_pkg::quo3_t out_quo
);

  localparam int NS = rbv_pkg::SQRT_STEPS;
  localparam int NQ = rbv_pkg::QUO_BITS;
  localparam int RW = rbv_pkg::MAG_W + 1;

  logic [rbv_pkg::SD_LAT-1:0] v_r;

  logic [64:0]    sn_r [NS];
  logic [64:0]    sr_r [NS];
  logic [64:0]    sn_nxt [NS];
  logic [64:0]    sr_nxt [NS];
  logic [64:0]    n_src [NS];
  logic [64:0]    r_src [NS];
  logic [64:0]    trial [NS];
  rbv_pkg::mag3_t sm_r [NS];
  logic [2:0]     sg_r [NS];

  logic [31:0]    root, den_nxt;
  logic [2:0][RW-1:0] fx_rem_nxt;
  logic [2:0]     fx_ovf_nxt;
  logic [31:0]    fx_den_r;
  logic [2:0][RW-1:0] fx_rem_r;
  logic [2:0]     fx_neg_r, fx_ovf_r;

  logic [2:0][RW-1:0] dr_r [NQ];
  logic [2:0][RW-1:0] dr_nxt [NQ];
  logic [2:0][NQ-1:0] dq_r [NQ];
  logic [2:0][NQ-1:0] dq_nxt [NQ];
  logic [31:0]    dd_r [NQ];
  logic [2:0]     dn_r [NQ];
  logic [2:0]     do_r [NQ];
  logic [2:0][RW-1:0] d_rem_src [NQ];
  logic [2:0][NQ-1:0] d_q_src [NQ];
  logic [31:0]    d_den_src [NQ];
  logic [64:0]    dsh [NQ];

  logic [NQ-1:0]  fin_q [3];
  rbv_pkg::quo3_t quo_nxt;
  rbv_pkg::quo3_t quo_r;
  logic [31:0]    root_r;

  // Square root: each stage tries one bit of the root.
  always_comb begin
    n_src[0] = {1'b0, in_sum};
    r_src[0] = '0;
    for (int j = 1; j < NS; j++) begin
      n_src[j] = sn_r[j-1];
      r_src[j] = sr_r[j-1];
    end
    for (int j = 0; j < NS; j++) begin
      trial[j] = r_src[j] + (65'(1) << (2 * (NS - 1 - j)));
      if (n_src[j] >= trial[j]) begin
        sn_nxt[j] = n_src[j] - trial[j];
        sr_nxt[j] = (r_src[j] >> 1) + (65'(1) << (2 * (NS - 1 - j)));
      end else begin
        sn_nxt[j] = n_src[j];
        sr_nxt[j] = r_src[j] >> 1;
      end
    end
  end

  // A zero root divides by one; the numerators are zero in that case.
  always_comb begin
    root    = sr_r[NS-1][31:0];
    den_nxt = (root == '0) ? 32'd1 : root;
    for (int i = 0; i < 3; i++) begin
      fx_rem_nxt[i] = RW'(sm_r[NS-1][i]) + RW'(den_nxt >> 1);
      fx_ovf_nxt[i] = (fx_rem_nxt[i] >> NQ) >= RW'(den_nxt);
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  always_comb begin
    d_rem_src[0] = fx_rem_r;
    d_q_src[0]   = '0;
    d_den_src[0] = fx_den_r;
    for (int k = 1; k < NQ; k++) begin
      d_rem_src[k] = dr_r[k-1];
      d_q_src[k]   = dq_r[k-1];
      d_den_src[k] = dd_r[k-1];
    end
    for (int k = 0; k < NQ; k++) begin
      dsh[k] = 65'(d_den_src[k]) << (NQ - 1 - k);
      for (int i = 0; i < 3; i++) begin
        if (65'(d_rem_src[k][i]) >= dsh[k]) begin
          dr_nxt[k][i] = RW'(65'(d_rem_src[k][i]) - dsh[k]);
          dq_nxt[k][i] = {d_q_src[k][i][NQ-2:0], 1'b1};
        end else begin
          dr_nxt[k][i] = d_rem_src[k][i];
          dq_nxt[k][i] = {d_q_src[k][i][NQ-2:0], 1'b0};
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      fin_q[i]   = do_r[NQ-1][i] ? '1 : dq_r[NQ-1][i];
      quo_nxt[i] = dn_r[NQ-1][i] ? rbv_pkg::QW'(-{2'b00, fin_q[i]})
                                 : rbv_pkg::QW'({2'b00, fin_q[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[rbv_pkg::SD_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r <= sn_nxt;
      sr_r <= sr_nxt;
      sm_r[0] <= in_mag;
      sg_r[0] <= in_neg;
      for (int j = 1; j < NS; j++) begin
        sm_r[j] <= sm_r[j-1];
        sg_r[j] <= sg_r[j-1];
      end
      fx_den_r <= den_nxt;
      fx_rem_r <= fx_rem_nxt;
      fx_neg_r <= sg_r[NS-1];
      fx_ovf_r <= fx_ovf_nxt;
      dr_r <= dr_nxt;
      dq_r <= dq_nxt;
      dd_r[0] <= fx_den_r;
      dn_r[0] <= fx_neg_r;
      do_r[0] <= fx_ovf_r;
      for (int k = 1; k < NQ; k++) begin
        dd_r[k] <= dd_r[k-1];
        dn_r[k] <= dn_r[k-1];
        do_r[k] <= do_r[k-1];
      end
      quo_r  <= quo_nxt;
      root_r <= dd_r[NQ-1];
    end
  end

  assign out_valid = v_r[rbv_pkg::SD_LAT-1];
  assign out_root  = root_r;
  assign out_quo   = quo_r;

endmodule

// ===== rtl/core/rotation_between_vectors_unit.sv =====
// Rotation between two vectors. Each input item carries a start and a
// destination vector of signed 16-bit components at any scale; each result
// item is the unit quaternion that turns start onto destination, in signed
// Q1.14 and saturated to +/-1.0. Both vectors are scaled, reduced to unit
// length by a pipelined square root and divider, and combined through their
// dot and cross products. When the cosine falls below -0.999 the half-turn
// about an axis perpendicular to start is returned and tuser bit 0 is set.
// When either vector is all zero the identity is returned and tuser bit 1 is
// set. The block is a fully pipelined datapath: it takes one item in every
// cycle while it is not stalled, the depth of the pipeline being set by the two
// square-root-and-divide units in series on its path (67 stages each). Back
// pressure on the result side stalls the whole pipeline only when a finished
// result is already waiting in the output register and another one is ready
// behind it; empty stages keep flowing in the meantime.
module rotation_between_vectors_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // start_x, start_y, start_z, dest_x, dest_y, dest_z from the lowest bit up
  input  logic [rbv_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // quat_w, quat_x, quat_y, quat_z from the lowest bit up
  output logic [rbv_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // opposite_case, zero_vector from the lowest bit up
  output logic [1:0]                         out_tuser
);

  localparam int VW = rbv_pkg::VW;

  logic en;

  // Input unpacking, sign extended to the working width.
  rbv_pkg::vec_t vin_s, vin_d;

  // Unit-length stage for both input vectors.
  logic           pa_v, pa_zs, pa_zd, pa_vd;
  logic [63:0]    pa_sum_s, pa_sum_d;
  rbv_pkg::mag3_t pa_mag_s, pa_mag_d;
  logic [2:0]     pa_neg_s, pa_neg_d;
  logic           za_r [rbv_pkg::SD_LAT];

  logic           sa_v, sa_vd;
  logic [31:0]    sa_root_s, sa_root_d;
  rbv_pkg::quo3_t qa_s, qa_d;
  rbv_pkg::vec_t  ua, ub;

  // Product stages.
  logic signed [63:0] c1_dot_nxt [3];
  logic signed [63:0] c1_cr_nxt [6];
  logic signed [63:0] c1_sq_nxt [2];
  logic signed [63:0] c1_dot_r [3];
  logic signed [63:0] c1_cr_r [6];
  logic signed [63:0] c1_sq_r [2];
  rbv_pkg::vec_t      c1_ua_r;
  logic               c1_v_r, c1_z_r;

  logic signed [63:0] c2_c60_r;
  logic signed [63:0] c2_cross_r [3];
  logic               c2_small_r;
  rbv_pkg::vec_t      c2_ua_r;
  logic               c2_v_r, c2_z_r;

  logic [63:0]        c3_cmag_abs [3];
  logic [63:0]        c3_abs;
  logic [33:0]        c3_round;
  logic signed [33:0] c3_c30_nxt;
  rbv_pkg::vec_t      c3_axis_nxt;
  logic signed [33:0] c3_c30_r;
  rbv_pkg::vec_t      c3_axis_r;
  rbv_pkg::mag3_t     c3_cmag_r;
  logic [2:0]         c3_cneg_r;
  logic               c3_v_r, c3_z_r;

  // Axis normalization for the half-turn case, with the ordinary path delayed
  // alongside it.
  logic           pb_v, pb_zero;
  logic [63:0]    pb_sum;
  rbv_pkg::mag3_t pb_mag;
  logic [2:0]     pb_neg;
  logic           nd_opp_r [rbv_pkg::PN_LAT];
  logic [63:0]    nd_x_r [rbv_pkg::PN_LAT];
  rbv_pkg::mag3_t nd_mag_r [rbv_pkg::PN_LAT];
  logic [2:0]     nd_neg_r [rbv_pkg::PN_LAT];
  logic           nd_z_r [rbv_pkg::PN_LAT];
  logic           nd_opp_nxt;
  logic [63:0]    nd_x_nxt;

  logic           last_opp, last_z;
  logic [63:0]    sb_sum_in;
  rbv_pkg::mag3_t sb_mag_in;
  logic [2:0]     sb_neg_in;
  logic [1:0]     ob_r [rbv_pkg::SD_LAT];

  logic           sb_v;
  logic [31:0]    sb_root;
  rbv_pkg::quo3_t sb_quo;

  logic [rbv_pkg::QW-1:0]  q0;
  logic [rbv_pkg::OUT_TDATA_W-1:0] out_data_nxt;
  logic [1:0]              out_user_nxt;
  logic                    out_valid_r;
  logic [rbv_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [1:0]              out_user_r;

  // The pipeline moves unless a waiting result would be overwritten.
  assign en        = !out_valid_r || out_tready || !sb_v;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vin_s[i] = VW'($signed(in_tdata[rbv_pkg::IN_W*i +: rbv_pkg::IN_W]));
      vin_d[i] = VW'($signed(in_tdata[rbv_pkg::IN_W*(i+3) +: rbv_pkg::IN_W]));
    end
  end

  rbv_prenorm u_pn_start (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_vec    (vin_s),
    .out_valid (pa_v),
    .out_zero  (pa_zs),
    .out_sum   (pa_sum_s),
    .out_mag   (pa_mag_s),
    .out_neg   (pa_neg_s)
  );

  rbv_prenorm u_pn_dest (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_vec    (vin_d),
    .out_valid (pa_vd),
    .out_zero  (pa_zd),
    .out_sum   (pa_sum_d),
    .out_mag   (pa_mag_d),
    .out_neg   (pa_neg_d)
  );

  rbv_sqrtdiv u_sd_start (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pa_v),
    .in_sum    (pa_sum_s),
    .in_mag    (pa_mag_s),
    .in_neg    (pa_neg_s),
    .out_valid (sa_v),
    .out_root  (sa_root_s),
    .out_quo   (qa_s)
  );

  rbv_sqrtdiv u_sd_dest (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pa_vd),
    .in_sum    (pa_sum_d),
    .in_mag    (pa_mag_d),
    .in_neg    (pa_neg_d),
    .out_valid (sa_vd),
    .out_root  (sa_root_d),
    .out_quo   (qa_d)
  );

  // Unit components stay within +/-2^30, so the low word holds them exactly.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ua[i] = qa_s[i][VW-1:0];
      ub[i] = qa_d[i][VW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      c1_dot_nxt[i] = $signed(ua[i]) * $signed(ub[i]);
    end
    c1_cr_nxt[0] = $signed(ua[1]) * $signed(ub[2]);
    c1_cr_nxt[1] = $signed(ua[2]) * $signed(ub[1]);
    c1_cr_nxt[2] = $signed(ua[2]) * $signed(ub[0]);
    c1_cr_nxt[3] = $signed(ua[0]) * $signed(ub[2]);
    c1_cr_nxt[4] = $signed(ua[0]) * $signed(ub[1]);
    c1_cr_nxt[5] = $signed(ua[1]) * $signed(ub[0]);
    c1_sq_nxt[0] = $signed(ua[0]) * $signed(ua[0]);
    c1_sq_nxt[1] = $signed(ua[1]) * $signed(ua[1]);
  end

  // Cosine rounded to Q.30, half-turn axis choice, cross product magnitudes.
  always_comb begin
    c3_abs     = c2_c60_r[63] ? 64'(-c2_c60_r) : 64'(c2_c60_r);
    c3_round   = 34'((c3_abs + (64'd1 << (rbv_pkg::UNIT_SHIFT - 1))) >> rbv_pkg::UNIT_SHIFT);
    c3_c30_nxt = c2_c60_r[63] ? -$signed(c3_round) : $signed(c3_round);
    if (c2_small_r) begin
      c3_axis_nxt[0] = '0;
      c3_axis_nxt[1] = VW'(-c2_ua_r[2]);
      c3_axis_nxt[2] = c2_ua_r[1];
    end else begin
      c3_axis_nxt[0] = VW'(-c2_ua_r[1]);
      c3_axis_nxt[1] = c2_ua_r[0];
      c3_axis_nxt[2] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      c3_cmag_abs[i] = c2_cross_r[i][63] ? 64'(-c2_cross_r[i]) : 64'(c2_cross_r[i]);
    end
  end

  // Square-root argument 2(1 + c) in Q.60 for the ordinary case.
  always_comb begin
    nd_opp_nxt = c3_c30_r < rbv_pkg::OPP_THRESHOLD;
    nd_x_nxt   = (64'(c3_c30_r) + (64'd1 << rbv_pkg::UNIT_SHIFT)) << (rbv_pkg::UNIT_SHIFT + 1);
  end

  rbv_prenorm u_pn_axis (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c3_v_r),
    .in_vec    (c3_axis_r),
    .out_valid (pb_v),
    .out_zero  (pb_zero),
    .out_sum   (pb_sum),
    .out_mag   (pb_mag),
    .out_neg   (pb_neg)
  );

  // A zero axis needs no flag: its numerators are zero and so is the result.
  always_comb begin
    last_opp  = nd_opp_r[rbv_pkg::PN_LAT-1];
    last_z    = nd_z_r[rbv_pkg::PN_LAT-1] | (pb_zero & 1'b0);
    sb_sum_in = last_opp ? pb_sum : nd_x_r[rbv_pkg::PN_LAT-1];
    sb_mag_in = last_opp ? pb_mag : nd_mag_r[rbv_pkg::PN_LAT-1];
    sb_neg_in = last_opp ? pb_neg : nd_neg_r[rbv_pkg::PN_LAT-1];
  end

  rbv_sqrtdiv u_sd_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pb_v),
    .in_sum    (sb_sum_in),
    .in_mag    (sb_mag_in),
    .in_neg    (sb_neg_in),
    .out_valid (sb_v),
    .out_root  (sb_root),
    .out_quo   (sb_quo)
  );

  // Result assembly: w is half the root, or zero for a half turn.
  always_comb begin
    q0 = ob_r[rbv_pkg::SD_LAT-1][0] ? '0 : rbv_pkg::QW'(sb_root >> 1);
    if (ob_r[rbv_pkg::SD_LAT-1][1]) begin
      out_data_nxt = rbv_pkg::OUT_TDATA_W'(
        rbv_pkg::to_out(rbv_pkg::QW'(1) << rbv_pkg::UNIT_SHIFT));
      out_user_nxt = 2'b10;
    end else begin
      out_data_nxt = {rbv_pkg::to_out(sb_quo[2]), rbv_pkg::to_out(sb_quo[1]),
                      rbv_pkg::to_out(sb_quo[0]), rbv_pkg::to_out(q0)};
      out_user_nxt = {1'b0, ob_r[rbv_pkg::SD_LAT-1][0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      c3_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= sa_v & sa_vd;
      c2_v_r <= c1_v_r;
      c3_v_r <= c2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za_r[0] <= pa_zs | pa_zd;
      for (int k = 1; k < rbv_pkg::SD_LAT; k++) begin
        za_r[k] <= za_r[k-1];
      end
      c1_dot_r <= c1_dot_nxt;
      c1_cr_r  <= c1_cr_nxt;
      c1_sq_r  <= c1_sq_nxt;
      c1_ua_r  <= ua;
      c1_z_r   <= za_r[rbv_pkg::SD_LAT-1];
      c2_c60_r      <= c1_dot_r[0] + c1_dot_r[1] + c1_dot_r[2];
      c2_cross_r[0] <= c1_cr_r[0] - c1_cr_r[1];
      c2_cross_r[1] <= c1_cr_r[2] - c1_cr_r[3];
      c2_cross_r[2] <= c1_cr_r[4] - c1_cr_r[5];
      c2_small_r    <= (c1_sq_r[0] + c1_sq_r[1]) < rbv_pkg::AXIS_THRESHOLD;
      c2_ua_r       <= c1_ua_r;
      c2_z_r        <= c1_z_r;
      c3_c30_r  <= c3_c30_nxt;
      c3_axis_r <= c3_axis_nxt;
      for (int i = 0; i < 3; i++) begin
        c3_cmag_r[i] <= c3_cmag_abs[i][rbv_pkg::MAG_W-1:0];
        c3_cneg_r[i] <= c2_cross_r[i][63];
      end
      c3_z_r <= c2_z_r;
      nd_opp_r[0] <= nd_opp_nxt;
      nd_x_r[0]   <= nd_x_nxt;
      nd_mag_r[0] <= c3_cmag_r;
      nd_neg_r[0] <= c3_cneg_r;
      nd_z_r[0]   <= c3_z_r;
      for (int k = 1; k < rbv_pkg::PN_LAT; k++) begin
        nd_opp_r[k] <= nd_opp_r[k-1];
        nd_x_r[k]   <= nd_x_r[k-1];
        nd_mag_r[k] <= nd_mag_r[k-1];
        nd_neg_r[k] <= nd_neg_r[k-1];
        nd_z_r[k]   <= nd_z_r[k-1];
      end
      ob_r[0] <= {last_z, last_opp};
      for (int k = 1; k < rbv_pkg::SD_LAT; k++) begin
        ob_r[k] <= ob_r[k-1];
      end
    end
  end

  // Output register: loaded whenever it is free or being emptied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= sb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A zero-length input always yields the identity and never the half turn.
  a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      !out_tuser[0] && out_tdata == rbv_pkg::OUT_TDATA_W'(16'h4000))
    else $error("zero input did not give the identity");

  // The half turn has a zero scalar part.
  a_opp_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[rbv_pkg::OUT_W-1:0] == '0)
    else $error("half turn with nonzero w");

  // The scalar part is half a square root and never negative.
  a_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[rbv_pkg::OUT_W-1])
    else $error("negative w");

  // With an empty last stage the input side is never held off.
  a_ready_on_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !sb_v |-> in_tready)
    else $error("input stalled behind an empty pipeline");

endmodule
